// ===== rtl/gse_pkg.sv =====
// Package for the Grafcet scan engine: shared request, CSR and program-word constants.
// No dependencies; imported by the engine top level.
`timescale 1ns / 1ps
package gse_pkg;
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_SCAN    = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;
   localparam logic [1:0] OP_RESTART = 2'd3;

   localparam logic [1:0] SEL_ENTRY  = 2'd0;
   localparam logic [1:0] SEL_EXIT   = 2'd1;
   localparam logic [1:0] SEL_ACTION = 2'd2;
   localparam logic [1:0] SEL_PROG   = 2'd3;

   localparam logic [2:0] CSR_TRANS  = 3'd0;
   localparam logic [2:0] CSR_STEPS  = 3'd1;
   localparam logic [2:0] CSR_ACTS   = 3'd2;
   localparam logic [2:0] CSR_INPUTS = 3'd3;
   localparam logic [2:0] CSR_INIT   = 3'd4;

   localparam logic [2:0] OPC_OR   = 3'd0;
   localparam logic [2:0] OPC_AND  = 3'd1;
   localparam logic [2:0] OPC_NOT  = 3'd2;
   localparam logic [2:0] OPC_EDGE = 3'd3;
   localparam logic [2:0] OPC_TRUE = 3'd4;

   localparam logic [1:0] OPD_INPUT  = 2'd0;
   localparam logic [1:0] OPD_OUTPUT = 2'd1;
   localparam logic [1:0] OPD_STEP   = 2'd2;
   localparam logic [1:0] OPD_TIME   = 2'd3;
endpackage

// ===== rtl/gse_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gse_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/grafcet_scan_engine_top.sv =====
// Grafcet scan engine: sequencer around entry, exit, action and program-word RAMs and one bit-stack evaluator.
// Tick updates one timer per cycle.
// Scan: per transition, mask and length reads, then the program words one by one;
// then the firing masks are applied and the outputs updated from the action masks.
// One request at a time; the result register holds until taken.
// Synchronous active-high reset clears steps, outputs, timers, edge slots and config.
`timescale 1ns / 1ps
module grafcet_scan_engine_top #(
   parameter int MAX_TRANS   = 16,
   parameter int PROG_LEN    = 32,
   parameter int EDGE_SLOTS  = 16,
   parameter int STACK_DEPTH = 20,
   parameter int MAX_STEPS   = 16,
   parameter int MAX_ACTIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [1:0]  req_table_sel,
   input  logic [3:0]  req_row,
   input  logic [4:0]  req_col,
   input  logic [15:0] req_word,
   input  logic [15:0] req_in_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_step_set,
   output logic [15:0] rsp_out_bits,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import gse_pkg::*;

   localparam int PW = $clog2(PROG_LEN);
   localparam int AW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
   localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int EW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
   localparam int KW = $clog2(STACK_DEPTH + 1);
   localparam int MW = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
   localparam int PAW = $clog2(MAX_TRANS * PROG_LEN);

   typedef enum logic [3:0] {
      S_IDLE, S_TRANS, S_MASKW, S_LEN, S_FETCH, S_WORD, S_SLOT, S_FINISH,
      S_APPLY, S_ACT, S_TICK, S_DONE
   } state_type;

   state_type state_ff;
   logic [4:0]  trans_cnt_ff, step_cnt_ff, act_cnt_ff, in_cnt_ff;
   logic [15:0] init_ff;
   logic [15:0] steps_ff, outs_ff, outv_ff, va_ff, vd_ff, entry_ff, inb_ff;
   logic [15:0] timer_ff [MAX_STEPS];
   logic [EDGE_SLOTS-1:0] edge_ff;
   logic [STACK_DEPTH-1:0] stack_ff;
   logic [KW-1:0] sp_ff;
   logic bad_ff;
   logic [4:0] idx_ff;
   logic [PW-1:0] pc_ff, len_ff;
   logic [1:0] sel_ff;
   logic rsp_valid_ff;

   // table RAMs
   logic        ent_we, ext_we, act_we, prg_we;
   logic [15:0] ent_rd, ext_rd, act_rd, prg_rd;
   logic [PAW-1:0] prg_waddr, prg_raddr;
   logic [MW-1:0] mrd_addr;
   logic [AW-1:0] ard_addr;
   logic accept;

   assign accept = req_valid && !req_stall;
   assign ent_we = accept && req_op == OP_LOAD && req_table_sel == SEL_ENTRY
                   && 32'(req_row) < MAX_TRANS;
   assign ext_we = accept && req_op == OP_LOAD && req_table_sel == SEL_EXIT
                   && 32'(req_row) < MAX_TRANS;
   assign act_we = accept && req_op == OP_LOAD && req_table_sel == SEL_ACTION
                   && 32'(req_row) < MAX_ACTIONS;
   assign prg_we = accept && req_op == OP_LOAD && req_table_sel == SEL_PROG
                   && 32'(req_row) < MAX_TRANS && 32'(req_col) < PROG_LEN;
   assign prg_waddr = PAW'(32'(req_row) * PROG_LEN + 32'(req_col));
   assign prg_raddr = PAW'(32'(idx_ff) * PROG_LEN + 32'(pc_ff));
   assign mrd_addr = MW'(idx_ff);
   assign ard_addr = AW'(idx_ff);

   gse_ram #(.WIDTH(16), .DEPTH(MAX_TRANS)) u_entry (
      .clock(clock), .wr_en(ent_we), .wr_addr(MW'(req_row)), .wr_data(req_word),
      .rd_addr(mrd_addr), .rd_data(ent_rd));
   gse_ram #(.WIDTH(16), .DEPTH(MAX_TRANS)) u_exit (
      .clock(clock), .wr_en(ext_we), .wr_addr(MW'(req_row)), .wr_data(req_word),
      .rd_addr(mrd_addr), .rd_data(ext_rd));
   gse_ram #(.WIDTH(16), .DEPTH(MAX_ACTIONS)) u_action (
      .clock(clock), .wr_en(act_we), .wr_addr(AW'(req_row)), .wr_data(req_word),
      .rd_addr(ard_addr), .rd_data(act_rd));
   gse_ram #(.WIDTH(16), .DEPTH(MAX_TRANS * PROG_LEN)) u_prog (
      .clock(clock), .wr_en(prg_we), .wr_addr(prg_waddr), .wr_data(req_word),
      .rd_addr(prg_raddr), .rd_data(prg_rd));

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_step_set = steps_ff;
   assign rsp_out_bits = outs_ff;

   // clamped counts
   logic [4:0] n_trans, n_acts, n_steps;
   assign n_trans = (32'(trans_cnt_ff) < MAX_TRANS) ? trans_cnt_ff : 5'(MAX_TRANS);
   assign n_acts  = (32'(act_cnt_ff) < MAX_ACTIONS) ? act_cnt_ff : 5'(MAX_ACTIONS);
   assign n_steps = (32'(step_cnt_ff) < MAX_STEPS) ? step_cnt_ff : 5'(MAX_STEPS);

   // operand evaluation of the current program word
   logic opd;
   logic [7:0] oidx;
   logic [3:0] tidx;
   always_comb begin
      oidx = prg_rd[7:0];
      tidx = prg_rd[11:8];
      opd = 1'b0;
      case (prg_rd[14:13])
         OPD_INPUT:  opd = ({3'b0, in_cnt_ff} > oidx) && inb_ff[oidx[3:0]];
         OPD_OUTPUT: opd = ({3'b0, act_cnt_ff} > oidx) && outs_ff[oidx[3:0]];
         OPD_STEP:   opd = (step_cnt_ff > prg_rd[4:0]) && steps_ff[prg_rd[3:0]];
         default: begin
            if (steps_ff[tidx] && 32'(tidx) < MAX_STEPS)
               opd = timer_ff[SW'(tidx)] >= {8'b0, prg_rd[7:0]};
         end
      endcase
   end

   // stack access helpers
   logic top0, top1;
   assign top0 = (sp_ff >= KW'(1)) ? stack_ff[KW'(sp_ff - KW'(1))] : 1'b0;
   assign top1 = (sp_ff >= KW'(2)) ? stack_ff[KW'(sp_ff - KW'(2))] : 1'b0;

   logic [15:0] tmr_cur;
   assign tmr_cur = timer_ff[SW'(idx_ff)];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         trans_cnt_ff <= '0; step_cnt_ff <= '0; act_cnt_ff <= '0; in_cnt_ff <= '0;
         init_ff <= '0; steps_ff <= '0; outs_ff <= '0; edge_ff <= '0;
         rsp_valid_ff <= 1'b0;
         sel_ff <= '0;
         for (int i = 0; i < MAX_STEPS; i++) timer_ff[i] <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         // configuration writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TRANS:  trans_cnt_ff <= csr_data[4:0];
               CSR_STEPS:  step_cnt_ff  <= csr_data[4:0];
               CSR_ACTS:   act_cnt_ff   <= csr_data[4:0];
               CSR_INPUTS: in_cnt_ff    <= csr_data[4:0];
               CSR_INIT:   init_ff      <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  idx_ff <= '0;
                  inb_ff <= req_in_bits;
                  case (req_op)
                     OP_LOAD: state_ff <= S_DONE;
                     OP_SCAN: begin
                        va_ff <= '0; vd_ff <= '0;
                        state_ff <= S_TRANS;
                     end
                     OP_TICK: state_ff <= S_TICK;
                     default: begin
                        steps_ff <= init_ff; outs_ff <= '0; edge_ff <= '0;
                        for (int i = 0; i < MAX_STEPS; i++) timer_ff[i] <= '0;
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            // start a transition: issue mask and length reads
            S_TRANS: begin
               pc_ff <= '0;
               if (idx_ff >= n_trans) begin
                  idx_ff <= '0; outv_ff <= '0;
                  state_ff <= S_APPLY;
               end else begin
                  state_ff <= S_MASKW;
               end
            end
            S_MASKW: state_ff <= S_LEN;
            S_LEN: begin
               entry_ff <= ent_rd;
               len_ff <= (prg_rd > 16'(PROG_LEN - 1)) ? PW'(PROG_LEN - 1) : PW'(prg_rd);
               sp_ff <= '0; bad_ff <= 1'b0;
               pc_ff <= PW'(1);
               state_ff <= S_FETCH;
            end
            S_FETCH: state_ff <= (pc_ff > len_ff || len_ff == '0) ? S_FINISH : S_WORD;
            // execute one program word
            S_WORD: begin
               if (prg_rd[15]) begin
                  if (32'(sp_ff) < STACK_DEPTH) begin
                     stack_ff[KW'(sp_ff)] <= opd; sp_ff <= sp_ff + KW'(1);
                  end else bad_ff <= 1'b1;
                  pc_ff <= pc_ff + PW'(1);
                  state_ff <= (pc_ff == len_ff) ? S_FINISH : S_FETCH;
               end else begin
                  case (prg_rd[14:12])
                     OPC_OR, OPC_AND: begin
                        if (sp_ff < KW'(2)) bad_ff <= 1'b1;
                        if (sp_ff >= KW'(2)) begin
                           stack_ff[KW'(sp_ff - KW'(2))] <= (prg_rd[12]) ?
                              (top0 && top1) : (top0 || top1);
                           sp_ff <= sp_ff - KW'(1);
                        end else begin
                           stack_ff[0] <= (prg_rd[12]) ? 1'b0 : top0;
                           sp_ff <= KW'(1);
                        end
                     end
                     OPC_NOT: begin
                        if (sp_ff == '0) begin
                           bad_ff <= 1'b1; stack_ff[0] <= 1'b1; sp_ff <= KW'(1);
                        end else stack_ff[KW'(sp_ff - KW'(1))] <= !top0;
                     end
                     OPC_TRUE: begin
                        if (32'(sp_ff) < STACK_DEPTH) begin
                           stack_ff[KW'(sp_ff)] <= 1'b1; sp_ff <= sp_ff + KW'(1);
                        end else bad_ff <= 1'b1;
                     end
                     default: ;
                  endcase
                  if (prg_rd[14:12] == OPC_EDGE) begin
                     if (pc_ff == len_ff) begin
                        bad_ff <= 1'b1;
                        state_ff <= S_FINISH;
                     end else begin
                        pc_ff <= pc_ff + PW'(1);
                        state_ff <= S_SLOT;
                     end
                  end else begin
                     pc_ff <= pc_ff + PW'(1);
                     state_ff <= (pc_ff == len_ff) ? S_FINISH : S_FETCH;
                  end
               end
            end
            // wait for slot word read, then apply the edge operator
            S_SLOT: begin
               if (sel_ff == 2'd1) begin
                  sel_ff <= 2'd0;
                  if (sp_ff == '0) begin
                     bad_ff <= 1'b1; stack_ff[0] <= 1'b0; sp_ff <= KW'(1);
                  end else begin
                     stack_ff[KW'(sp_ff - KW'(1))] <= top0 &&
                        !((prg_rd < 16'(EDGE_SLOTS)) && edge_ff[EW'(prg_rd)]);
                  end
                  if (prg_rd < 16'(EDGE_SLOTS)) edge_ff[EW'(prg_rd)] <= top0;
                  pc_ff <= pc_ff + PW'(1);
                  state_ff <= (pc_ff == len_ff) ? S_FINISH : S_FETCH;
               end else sel_ff <= 2'd1;
            end
            // accumulate firing masks
            S_FINISH: begin
               if (!bad_ff && sp_ff != '0 && top0 && ((steps_ff & entry_ff) == entry_ff))
               begin
                  va_ff <= va_ff | ext_rd;
                  vd_ff <= vd_ff | entry_ff;
               end
               idx_ff <= idx_ff + 5'd1;
               state_ff <= S_TRANS;
            end
            S_APPLY: begin
               steps_ff <= (steps_ff & ~vd_ff) | va_ff;
               state_ff <= S_ACT;
            end
            // one action mask per cycle; read data is registered and belongs to the previous index
            S_ACT: begin
               if (idx_ff != '0 && act_rd != '0 && (steps_ff & act_rd) != '0)
                  outv_ff[4'(idx_ff - 5'd1)] <= 1'b1;
               if (idx_ff >= n_acts) begin
                  outs_ff <= ((idx_ff != '0 && (steps_ff & act_rd) != '0) ?
                     (outv_ff | (16'd1 << (idx_ff - 5'd1))) : outv_ff);
                  state_ff <= S_DONE;
               end else idx_ff <= idx_ff + 5'd1;
            end
            S_TICK: begin
               if (idx_ff >= n_steps) state_ff <= S_DONE;
               else begin
                  if (!steps_ff[4'(idx_ff)]) timer_ff[SW'(idx_ff)] <= '0;
                  else if (tmr_cur != 16'hFFFF) timer_ff[SW'(idx_ff)] <= tmr_cur + 16'd1;
                  idx_ff <= idx_ff + 5'd1;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/gse_checker.sv =====
// Port-level checker for the Grafcet scan engine, bound to the top level.
// Depends on grafcet_scan_engine_top ports only.
`timescale 1ns / 1ps
module gse_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_step_set,
   input logic [15:0] rsp_out_bits
);
   // one request at a time: no accept while a result waits
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request accepted with result pending");
   // an accepted request makes the engine stall requests in the next cycle
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("engine took two requests");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_step_set)
      && $stable(rsp_out_bits))) else $error("stalled result changed");
   // result comes out of reset empty
   a_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid) else $error("result valid after reset");
endmodule

bind grafcet_scan_engine_top gse_checker u_gse_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_step_set(rsp_step_set),
   .rsp_out_bits(rsp_out_bits));
